// ===== rtl/xtea_block_cipher_unit_assert.svh =====
// Assertion macros for the XTEA unit; all checks run on clk and are off in reset.
`ifndef XTEA_BLOCK_CIPHER_UNIT_ASSERT_SVH
`define XTEA_BLOCK_CIPHER_UNIT_ASSERT_SVH

// Property that must hold at every edge.
`define XTEA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Antecedent this cycle implies consequent at the next edge.
`define XTEA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) \
		(ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/xtea_pkg.sv =====
package xtea_pkg;

	localparam int          WORD_W    = 32;
	localparam int          KEY_WORDS = 4;
	localparam int          ADDR_W    = 4;
	localparam logic [31:0] DELTA     = 32'h9E3779B9;

	typedef logic [WORD_W-1:0] word_t;
	typedef word_t [KEY_WORDS-1:0] key_t;

	typedef struct packed {
		word_t v0;
		word_t v1;
	} xtea_blk_t;

	typedef struct packed {
		logic      kind;   // 0 encrypt, 1 decrypt
		xtea_blk_t blk;
	} xtea_stage_t;

	localparam logic KIND_ENC = 1'b0;
	localparam logic KIND_DEC = 1'b1;

	function automatic word_t mix(input word_t v);
		mix = ((v << 4) ^ (v >> 5)) + v;
	endfunction

endpackage

// ===== rtl/xtea_in_if.sv =====
interface xtea_in_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [31:0] half_first;
	logic [31:0] half_second;

	modport source(output valid, kind, half_first, half_second, input ready);
	modport sink(input valid, kind, half_first, half_second, output ready);
endinterface

// ===== rtl/xtea_out_if.sv =====
interface xtea_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_first;
	logic [31:0] out_second;

	modport source(output valid, out_first, out_second, input ready);
	modport sink(input valid, out_first, out_second, output ready);
endinterface

// ===== rtl/xtea_block_cipher_unit.sv =====
// XTEA block cipher unit, 64-bit block, ROUNDS rounds (32 by default), 128-bit key in four
// APB registers at byte addresses 0x0, 0x4, 0x8, 0xC (key word 0..3, reset to zero; write the
// key only while no request is in flight). Each request on blk_in carries kind (0 encrypt,
// 1 decrypt) and the halves v0/v1; each one yields exactly one response on blk_out, in order.
// Throughput is one request per clock while the skid register is empty. The datapath is a
// chain of 2*ROUNDS registered half-round stages, each one mix/xor/add (mix/xor/subtract
// for decrypt) on one half. When the response side stalls, the head response moves into a
// one-entry skid register and the whole chain holds, so blk_in.ready drops in the following
// cycle and is driven from that register only.
module xtea_block_cipher_unit #(
	parameter int ROUNDS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	xtea_in_if.sink                     blk_in,
	xtea_out_if.source                  blk_out,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [xtea_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	import xtea_pkg::*;

	localparam int NSTG = 2 * ROUNDS;

	key_t        key;
	logic        adv;          // whole chain advances
	logic        vld [0:NSTG];
	xtea_stage_t stg [0:NSTG];
	xtea_blk_t   skid_q;
	logic        skid_v_q;

	xtea_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.key     (key)
	);

	// chain holds while the skid register is occupied
	assign adv          = !skid_v_q;
	assign blk_in.ready = adv;

	assign vld[0]         = blk_in.valid;
	assign stg[0].kind    = blk_in.kind;
	assign stg[0].blk.v0  = blk_in.half_first;
	assign stg[0].blk.v1  = blk_in.half_second;

	// Stage j uses sum = k*DELTA for encrypt and (ROUNDS-k)*DELTA for decrypt,
	// with k = (j+1)/2; this covers both the pre- and post-increment halves.
	for (genvar j = 0; j < NSTG; j++) begin : g_stage
		localparam int          K_E = (j + 1) / 2;
		localparam int          K_D = ROUNDS - K_E;
		localparam logic [63:0] P_E = 64'(K_E) * 64'(DELTA);
		localparam logic [63:0] P_D = 64'(K_D) * 64'(DELTA);
		localparam bit          ODD = (j % 2) == 1;

		xtea_round #(
			.SUM_ENC (P_E[31:0]),
			.SUM_DEC (P_D[31:0]),
			.ODD     (ODD)
		) u_round (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv),
			.vld_i  (vld[j]),
			.stg_i  (stg[j]),
			.key    (key),
			.vld_o  (vld[j+1]),
			.stg_o  (stg[j+1])
		);
	end

	// skid: catch the head response when it is not taken while the chain moves
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (blk_out.ready) begin
				skid_v_q <= 1'b0;
			end
		end else if (vld[NSTG] && !blk_out.ready) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!skid_v_q && vld[NSTG] && !blk_out.ready) begin
			skid_q <= stg[NSTG].blk;
		end
	end

	// skid holds the older response; the chain head is next in line
	assign blk_out.valid      = skid_v_q | vld[NSTG];
	assign blk_out.out_first  = skid_v_q ? skid_q.v0 : stg[NSTG].blk.v0;
	assign blk_out.out_second = skid_v_q ? skid_q.v1 : stg[NSTG].blk.v1;

`include "xtea_block_cipher_unit_assert.svh"

	`XTEA_ASSERT_NEXT(a_skid_fill, !skid_v_q && vld[NSTG] && !blk_out.ready, skid_v_q, "stalled head response not captured in skid")
	`XTEA_ASSERT_NEXT(a_head_hold, skid_v_q, vld[NSTG] == $past(vld[NSTG]), "chain head moved while skid occupied")
	`XTEA_ASSERT(a_head_data_hold, !($past(skid_v_q) && vld[NSTG]) || $stable(stg[NSTG]) || !$past(vld[NSTG]), "chain head data changed while skid occupied")
endmodule

// ===== rtl/xtea_cfg.sv =====
module xtea_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [xtea_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output xtea_pkg::key_t            key
);
	import xtea_pkg::*;

	key_t       key_q;
	logic       wr_en;
	logic [1:0] idx;

	assign pready = 1'b1;
	assign idx    = paddr[3:2];
	assign wr_en  = psel & penable & pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (wr_en) begin
			key_q[idx] <= pwdata;
		end
	end

	assign prdata = key_q[idx];
	assign key    = key_q;
endmodule

// ===== rtl/xtea_round.sv =====
// One half-round: updates one half of the block, registered.
module xtea_round #(
	parameter logic [31:0] SUM_ENC = 32'h0,
	parameter logic [31:0] SUM_DEC = 32'h0,
	parameter bit          ODD     = 1'b0
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  en,
	input  logic                  vld_i,
	input  xtea_pkg::xtea_stage_t stg_i,
	input  xtea_pkg::key_t        key,
	output logic                  vld_o,
	output xtea_pkg::xtea_stage_t stg_o
);
	import xtea_pkg::*;

	logic        upd_v1;
	word_t       sum;
	logic [1:0]  kidx;
	word_t       src;
	word_t       dst;
	word_t       f;
	word_t       res;
	xtea_stage_t nxt;
	logic        vld_s1;
	xtea_stage_t stg_s1;

	// enc: even stages update v0, odd v1; dec swaps that
	assign upd_v1 = ODD ^ stg_i.kind;
	assign sum    = (stg_i.kind == KIND_DEC) ? SUM_DEC : SUM_ENC;
	assign kidx   = upd_v1 ? sum[12:11] : sum[1:0];
	assign src    = upd_v1 ? stg_i.blk.v0 : stg_i.blk.v1;
	assign dst    = upd_v1 ? stg_i.blk.v1 : stg_i.blk.v0;
	assign f      = mix(src) ^ (sum + key[kidx]);
	assign res    = (stg_i.kind == KIND_DEC) ? (dst - f) : (dst + f);

	always_comb begin
		nxt = stg_i;
		if (upd_v1) begin
			nxt.blk.v1 = res;
		end else begin
			nxt.blk.v0 = res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en && vld_i) begin
			stg_s1 <= nxt;
		end
	end

	assign vld_o = vld_s1;
	assign stg_o = stg_s1;
endmodule
